FILE: hdl/ssdw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssdw_pkg;

   typedef enum logic [1:0] {
      CMD_TEXT   = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_BRIGHT = 2'd2,
      CMD_INIT   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      JOB_FLUSH  = 2'd0,
      JOB_BRIGHT = 2'd1,
      JOB_INIT   = 2'd2
   } job_kind_type;

   typedef struct packed {
      cmd_type           command;
      logic [7:0]        character;
      logic              end_of_text;
      logic signed [7:0] brightness;
   } req_type;

   typedef struct packed {
      logic [3:0] register_address;
      logic [7:0] register_data;
      logic       last_write;
   } rsp_type;

   typedef struct packed {
      job_kind_type kind;
      logic [3:0]   level;
   } job_type;

   // digit position and write step counters, sized for up to eight digits
   localparam int POS_W  = 3;
   localparam int STEP_W = 3;

   localparam logic [3:0] REG_DECODE    = 4'h9;
   localparam logic [3:0] REG_INTENSITY = 4'hA;
   localparam logic [3:0] REG_SCAN      = 4'hB;
   localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
   localparam logic [3:0] REG_TEST      = 4'hF;

   localparam logic [7:0] CODE_BLANK = 8'h0F;
   localparam logic [7:0] CODE_DASH  = 8'h0A;
   localparam logic [7:0] CODE_COLON = 8'h8F;
   localparam logic [7:0] CODE_DOT   = 8'h80;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_DASH  = 8'd45;
   localparam logic [7:0] CHAR_DOT   = 8'd46;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_COLON = 8'd58;

   localparam logic [3:0] LEVEL_MAX     = 4'd15;
   localparam logic [7:0] LEVEL_DEFAULT = 8'd5;
   localparam logic [7:0] DECODE_ALL    = 8'hFF;
   localparam logic [7:0] SHUTDOWN_OFF  = 8'd1;
   localparam logic [7:0] TEST_OFF      = 8'd0;

   localparam logic [STEP_W-1:0] INIT_LAST = 3'd4;

   // start-up sequence, one write per step
   function automatic rsp_type init_write(input logic [STEP_W-1:0] step,
                                          input logic [7:0] scan);
      rsp_type w;
      w.last_write = (step == INIT_LAST);
      case (step)
         3'd0: begin
            w.register_address = REG_SCAN;
            w.register_data    = scan;
         end
         3'd1: begin
            w.register_address = REG_DECODE;
            w.register_data    = DECODE_ALL;
         end
         3'd2: begin
            w.register_address = REG_SHUTDOWN;
            w.register_data    = SHUTDOWN_OFF;
         end
         3'd3: begin
            w.register_address = REG_TEST;
            w.register_data    = TEST_OFF;
         end
         default: begin
            w.register_address = REG_INTENSITY;
            w.register_data    = LEVEL_DEFAULT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/seven_segment_text_digit_writer.sv
// Text formatter for an eight-digit code-B seven-segment driver.
// req channel: one command item per handshake (text character, clear,
// brightness, initialise). rsp channel: driver register writes, in order,
// last_write marking the final write of the item that caused them.
// The front end updates the digit buffer and text state as items arrive and
// posts a job (digit flush, intensity write or start-up sequence) into a
// two-entry queue; the back end plays jobs out one write per cycle while
// rsp_stall is low. Throughput: text characters that produce no writes are
// taken one per cycle while the queue is not full; req_stall rises only
// while both queue entries are waiting. The first write of an item passes
// through the queue, the back end's job register and its output register
// before it is valid on rsp. While rsp_valid and rsp_stall are high the
// output register holds its write and the back end pauses; the front end
// keeps taking items until the queue fills.
// Reset clears the digit codes to zero, moves the write position to the
// highest digit, empties the queue and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_text_digit_writer import ssdw_pkg::*; #(
   parameter int DIGIT_COUNT    = 8,
   parameter int MAX_TEXT_CHARS = 12
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int QW = $bits(job_type) + DIGIT_COUNT * 8;

   logic                     q_push, q_pop, q_full, q_empty;
   job_type                  push_job, pop_job;
   logic [DIGIT_COUNT*8-1:0] push_digits, pop_digits;
   logic [QW-1:0]            pop_data;

   ssdw_front #(
      .DIGIT_COUNT   (DIGIT_COUNT),
      .MAX_TEXT_CHARS(MAX_TEXT_CHARS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job),
      .q_digits (push_digits)
   );

   ssdw_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data({push_job, push_digits}),
      .pop      (q_pop),
      .pop_data (pop_data),
      .full     (q_full),
      .empty    (q_empty)
   );

   assign pop_job    = job_type'(pop_data[QW-1 -: $bits(job_type)]);
   assign pop_digits = pop_data[DIGIT_COUNT*8-1:0];

   ssdw_back #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_job    (pop_job),
      .q_digits (pop_digits),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty queue");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_flush_ends_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_write && rsp_data.register_address >= 4'd1 &&
      rsp_data.register_address <= 4'(DIGIT_COUNT)
      |-> rsp_data.register_address == 4'(DIGIT_COUNT))
      else $error("digit flush ended before the top digit register");

endmodule

`default_nettype wire

FILE: hdl/ssdw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ssdw_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ssdw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ssdw_front import ssdw_pkg::*; #(
   parameter int DIGIT_COUNT    = 8,
   parameter int MAX_TEXT_CHARS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_data,
   input  wire logic                     q_full,
   output logic                          q_push,
   output job_type                       q_job,
   output logic [DIGIT_COUNT*8-1:0]      q_digits
);

   localparam logic [POS_W-1:0] POS_TOP   = POS_W'(DIGIT_COUNT - 1);
   localparam logic [3:0]       DIGIT_LIM = 4'(DIGIT_COUNT);
   localparam logic [3:0]       TEXT_LIM  = 4'(MAX_TEXT_CHARS);

   logic [DIGIT_COUNT*8-1:0] digits_ff, digits_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [3:0]               taken_ff, taken_in;
   logic                     finished_ff, finished_in;

   logic       accept;
   logic       push;
   logic       done;
   logic       put;
   logic [7:0] code;
   logic [7:0] ch;
   logic [3:0] taken_next;
   logic [3:0] pos_up;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && push;
   assign q_digits  = digits_in;
   assign ch        = req_data.character;

   always_comb begin
      digits_in   = digits_ff;
      pos_in      = pos_ff;
      taken_in    = taken_ff;
      finished_in = finished_ff;
      push        = 1'b0;
      done        = 1'b0;
      put         = 1'b0;
      code        = 8'd0;
      taken_next  = taken_ff + 4'd1;
      pos_up      = {1'b0, pos_ff} + 4'd1;
      q_job.kind  = JOB_FLUSH;
      q_job.level = 4'd0;

      unique case (req_data.command)
         CMD_TEXT: begin
            if (finished_ff) begin
               // text already flushed: only end_of_text rearms
               if (req_data.end_of_text) begin
                  pos_in      = POS_TOP;
                  taken_in    = 4'd0;
                  finished_in = 1'b0;
               end
            end else begin
               if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                  code = ch - CHAR_ZERO;
                  put  = 1'b1;
               end else if (ch == CHAR_SPACE) begin
                  code = CODE_BLANK;
                  put  = 1'b1;
               end else if (ch == CHAR_DASH) begin
                  code = CODE_DASH;
                  put  = 1'b1;
               end else if (ch == CHAR_COLON) begin
                  code = CODE_COLON;
                  put  = 1'b1;
               end else if (ch == CHAR_DOT) begin
                  // dot marks the digit written just before; none yet leaves the digits as they are
                  if (pos_up < DIGIT_LIM) begin
                     digits_in[{pos_up[POS_W-1:0], 3'b000} +: 8] =
                        digits_ff[{pos_up[POS_W-1:0], 3'b000} +: 8] + CODE_DOT;
                  end
               end

               if (ch != CHAR_NUL) begin
                  taken_in = taken_next;
                  if (put) begin
                     digits_in[{pos_ff, 3'b000} +: 8] = code;
                     if (pos_ff == '0) begin
                        done = 1'b1;
                     end else begin
                        pos_in = pos_ff - 1'b1;
                     end
                  end
                  if (taken_next >= TEXT_LIM) begin
                     done = 1'b1;
                  end
               end else begin
                  done = 1'b1;
               end

               if (req_data.end_of_text) begin
                  done = 1'b1;
               end

               if (done) begin
                  push     = 1'b1;
                  pos_in   = POS_TOP;
                  taken_in = 4'd0;
                  finished_in = !req_data.end_of_text;
               end
            end
         end
         CMD_CLEAR: begin
            digits_in = {DIGIT_COUNT{CODE_BLANK}};
            push      = 1'b1;
         end
         CMD_BRIGHT: begin
            q_job.kind = JOB_BRIGHT;
            if (req_data.brightness < 0) begin
               q_job.level = 4'd0;
            end else if (req_data.brightness > $signed({4'b0000, LEVEL_MAX})) begin
               q_job.level = LEVEL_MAX;
            end else begin
               q_job.level = req_data.brightness[3:0];
            end
            push = 1'b1;
         end
         CMD_INIT: begin
            q_job.kind = JOB_INIT;
            push       = 1'b1;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff   <= '0;
         pos_ff      <= POS_TOP;
         taken_ff    <= 4'd0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         digits_ff   <= digits_in;
         pos_ff      <= pos_in;
         taken_ff    <= taken_in;
         finished_ff <= finished_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ssdw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ssdw_back import ssdw_pkg::*; #(
   parameter int DIGIT_COUNT = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_empty,
   input  wire job_type                  q_job,
   input  wire logic [DIGIT_COUNT*8-1:0] q_digits,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_data
);

   localparam logic [STEP_W-1:0] FLUSH_LAST = STEP_W'(DIGIT_COUNT - 1);
   localparam logic [7:0]        SCAN_LIMIT = 8'(DIGIT_COUNT - 1);

   logic                     busy_ff, busy_in;
   job_type                  job_ff, job_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [DIGIT_COUNT*8-1:0] digits_ff, digits_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic    out_free;
   rsp_type wr;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = !busy_ff && !q_empty;

   always_comb begin
      case (job_ff.kind)
         JOB_FLUSH: begin
            wr.register_address = {1'b0, step_ff} + 4'd1;
            wr.register_data    = digits_ff[{step_ff, 3'b000} +: 8];
            wr.last_write       = (step_ff == FLUSH_LAST);
         end
         JOB_BRIGHT: begin
            wr.register_address = REG_INTENSITY;
            wr.register_data    = {4'b0000, job_ff.level};
            wr.last_write       = 1'b1;
         end
         default: begin
            wr = init_write(step_ff, SCAN_LIMIT);
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      digits_in    = digits_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (out_free) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            rsp_data_in = wr;
            step_in     = step_ff + 1'b1;
            busy_in     = !wr.last_write;
         end
      end

      // load the next job once the current one has issued its last write
      if (q_pop) begin
         busy_in   = 1'b1;
         job_in    = q_job;
         step_in   = '0;
         digits_in = q_digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      step_ff     <= step_in;
      digits_ff   <= digits_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
